// ===== rtl/velocity_command_limiter_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the velocity command limiter
// Clocked on clk, switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef VELOCITY_COMMAND_LIMITER_ASSERT_SVH
`define VELOCITY_COMMAND_LIMITER_ASSERT_SVH

// property that must hold at every edge
`define VCL_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define VCL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/vcl_pkg.sv =====
// ----------------------------------------------------------------------------
// vcl_pkg
// Shared types, register indexes, reset values and helpers.
// ----------------------------------------------------------------------------
package vcl_pkg;

  localparam int FRAC_BITS_DEF = 12;

  localparam logic [2:0] REG_TRANS_GAIN  = 3'd0;
  localparam logic [2:0] REG_ROT_GAIN    = 3'd1;
  localparam logic [2:0] REG_LIN_LIMITS  = 3'd2;
  localparam logic [2:0] REG_ROT_LIMITS  = 3'd3;
  localparam logic [2:0] REG_IP_MIN_ROT  = 3'd4;
  localparam logic [2:0] REG_IP_TRANS    = 3'd5;
  localparam logic [2:0] REG_HEAD_THR    = 3'd6;
  localparam logic [2:0] REG_MODE        = 3'd7;

  localparam logic [15:0] RST_TRANS_GAIN = 16'd4096;
  localparam logic [15:0] RST_ROT_GAIN   = 16'd4096;
  localparam logic [31:0] RST_LIN_LIMITS = 32'h0800_0000;
  localparam logic [31:0] RST_ROT_LIMITS = 32'h1000_0000;
  localparam logic [1:0]  RST_MODE       = 2'd1;

  typedef struct packed {
    logic [15:0] trans_gain;
    logic [15:0] rot_gain;
    logic [15:0] max_lin;
    logic [15:0] min_lin;
    logic [15:0] max_th;
    logic [15:0] min_th;
    logic [14:0] ip_min_rot;
    logic [14:0] head_thr;
    logic        holo;
    logic        turn_first;
    logic [31:0] max_lin_sq;
    logic [31:0] min_lin_sq;
    logic [29:0] ip_trans_sq;
  } cfg_t;

  typedef struct packed {
    logic zero_lin;
    logic need_over;
    logic need_under;
  } lin_ctl_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] yaw;
    logic [31:0]        sq;
    lin_ctl_t           ctl;
  } job_t;

  // sign and magnitude back to a saturated 16-bit signed value
  function automatic logic signed [15:0] sat_mag(input logic neg, input logic [32:0] mag);
    logic signed [15:0] res;
    if (!neg) begin
      res = (mag > 33'd32767) ? 16'sd32767 : $signed(mag[15:0]);
    end else begin
      res = (mag > 33'd32768) ? -16'sd32768 : $signed(-mag[15:0]);
    end
    return res;
  endfunction

  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    logic [16:0] w;
    w = v[15] ? -{v[15], v} : {v[15], v};
    return w[15:0];
  endfunction

endpackage

// ===== rtl/velocity_command_limiter.sv =====
// ----------------------------------------------------------------------------
// velocity_command_limiter
// Gains, speed limits and yaw clamps on a velocity request vector.
//
//  channel | ports                                  | handshake
//  --------+----------------------------------------+----------------------
//  in      | in_err_x, in_err_y, in_err_yaw         | in_push / in_full
//  out     | out_cmd_x, out_cmd_y, out_cmd_yaw      | out_pop / out_empty
//  cfg     | cfg_addr, cfg_data                     | cfg_valid / cfg_ready
//
// Front pipeline takes a request every cycle unless stalled by a full queue,
// into a 2-entry queue. Back end handles one request at a time: without speed
// scaling it goes straight to the output register; with it, 16 square-root
// steps, then one or two division passes on the one-bit-a-cycle divider.
// Reset is synchronous; the back end keeps working while a result waits.
// ----------------------------------------------------------------------------
module velocity_command_limiter #(
  parameter int FRAC_BITS = vcl_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic signed [15:0] in_err_x,
  input  logic signed [15:0] in_err_y,
  input  logic signed [15:0] in_err_yaw,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [15:0] out_cmd_x,
  output logic signed [15:0] out_cmd_y,
  output logic signed [15:0] out_cmd_yaw,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_addr,
  input  logic [31:0]        cfg_data
);

  vcl_pkg::cfg_t cfg;
  vcl_pkg::job_t push_job, pop_job;
  logic          q_push, q_full, q_pop, q_empty;

  assign cfg_ready = 1'b1;

  vcl_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_addr (cfg_addr),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  vcl_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_err_x   (in_err_x),
    .in_err_y   (in_err_y),
    .in_err_yaw (in_err_yaw),
    .q_push     (q_push),
    .q_full     (q_full),
    .q_job      (push_job)
  );

  vcl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  vcl_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .q_empty     (q_empty),
    .q_job       (pop_job),
    .q_pop       (q_pop),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_cmd_x   (out_cmd_x),
    .out_cmd_y   (out_cmd_y),
    .out_cmd_yaw (out_cmd_yaw)
  );

endmodule

// ===== rtl/vcl_cfg.sv =====
// ----------------------------------------------------------------------------
// vcl_cfg
// Configuration registers, registered squares of speed limits and ip_trans.
// ----------------------------------------------------------------------------
module vcl_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [2:0]         wr_addr,
  input  logic [31:0]        wr_data,
  output vcl_pkg::cfg_t      cfg
);

  logic [15:0] trans_gain_r, rot_gain_r;
  logic [31:0] lin_lim_r, rot_lim_r;
  logic [14:0] ip_min_rot_r, ip_trans_r, head_thr_r;
  logic [1:0]  mode_r;
  logic [31:0] max_sq_r, min_sq_r;
  logic [29:0] ip_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trans_gain_r <= vcl_pkg::RST_TRANS_GAIN;
      rot_gain_r   <= vcl_pkg::RST_ROT_GAIN;
      lin_lim_r    <= vcl_pkg::RST_LIN_LIMITS;
      rot_lim_r    <= vcl_pkg::RST_ROT_LIMITS;
      ip_min_rot_r <= '0;
      ip_trans_r   <= '0;
      head_thr_r   <= '0;
      mode_r       <= vcl_pkg::RST_MODE;
    end else if (wr_en) begin
      case (wr_addr)
        vcl_pkg::REG_TRANS_GAIN: trans_gain_r <= wr_data[15:0];
        vcl_pkg::REG_ROT_GAIN:   rot_gain_r   <= wr_data[15:0];
        vcl_pkg::REG_LIN_LIMITS: lin_lim_r    <= wr_data;
        vcl_pkg::REG_ROT_LIMITS: rot_lim_r    <= wr_data;
        vcl_pkg::REG_IP_MIN_ROT: ip_min_rot_r <= wr_data[14:0];
        vcl_pkg::REG_IP_TRANS:   ip_trans_r   <= wr_data[14:0];
        vcl_pkg::REG_HEAD_THR:   head_thr_r   <= wr_data[14:0];
        vcl_pkg::REG_MODE:       mode_r       <= wr_data[1:0];
        default: ;
      endcase
    end
  end

  // squares follow in the cycle after a write
  always_ff @(posedge clk) begin
    max_sq_r <= lin_lim_r[31:16] * lin_lim_r[31:16];
    min_sq_r <= lin_lim_r[15:0] * lin_lim_r[15:0];
    ip_sq_r  <= ip_trans_r * ip_trans_r;
  end

  always_comb begin
    cfg.trans_gain  = trans_gain_r;
    cfg.rot_gain    = rot_gain_r;
    cfg.max_lin     = lin_lim_r[31:16];
    cfg.min_lin     = lin_lim_r[15:0];
    cfg.max_th      = rot_lim_r[31:16];
    cfg.min_th      = rot_lim_r[15:0];
    cfg.ip_min_rot  = ip_min_rot_r;
    cfg.head_thr    = head_thr_r;
    cfg.holo        = mode_r[0];
    cfg.turn_first  = mode_r[1];
    cfg.max_lin_sq  = max_sq_r;
    cfg.min_lin_sq  = min_sq_r;
    cfg.ip_trans_sq = ip_sq_r;
  end

endmodule

// ===== rtl/vcl_front.sv =====
// ----------------------------------------------------------------------------
// vcl_front
// Four-stage pipeline: gains, rounding, squares, then classification and
// the whole yaw clamp. Stalls as a unit while stage 4 waits on a full queue.
// ----------------------------------------------------------------------------
module vcl_front #(
  parameter int FRAC_BITS = vcl_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  vcl_pkg::cfg_t      cfg,
  input  logic               in_push,
  output logic               in_full,
  input  logic signed [15:0] in_err_x,
  input  logic signed [15:0] in_err_y,
  input  logic signed [15:0] in_err_yaw,
  output logic               q_push,
  input  logic               q_full,
  output vcl_pkg::job_t      q_job
);

  localparam logic [32:0] RND = 33'd1 << (FRAC_BITS - 1);

  logic v1_r, v2_r, v3_r, v4_r;
  logic adv;

  // stage 1
  logic [31:0] px_r, py_r, pr_r, exsq_r, eysq_r;
  logic        nx_r, ny_r, nr_r;
  logic [15:0] eyaw_mag_r;
  // stage 2
  logic signed [15:0] x2_r, y2_r, r2_r;
  logic               small2_r, tf2_r;
  // stage 3
  logic signed [15:0] x3_r, y3_r, r3_r;
  logic [31:0]        xsq_r, ysq_r;
  logic               small3_r, tf3_r;
  // stage 4
  vcl_pkg::job_t      job_r;

  logic [15:0] mx, my, myaw;
  logic [32:0] rx, ry, rr;
  logic [32:0] rsq;
  logic signed [31:0] xsq_s, ysq_s;
  logic [31:0] sq;
  logic [15:0] rm, rm_c, lo;
  logic        zero_lin;

  assign adv     = !(v4_r && q_full);
  assign in_full = !adv;
  assign q_push  = v4_r && !q_full;
  assign q_job   = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_push;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_comb begin
    mx   = vcl_pkg::mag16(in_err_x);
    my   = vcl_pkg::mag16(in_err_y);
    myaw = vcl_pkg::mag16(in_err_yaw);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r       <= mx * cfg.trans_gain;
      py_r       <= my * cfg.trans_gain;
      pr_r       <= myaw * cfg.rot_gain;
      exsq_r     <= mx * mx;
      eysq_r     <= my * my;
      nx_r       <= in_err_x[15];
      ny_r       <= in_err_y[15];
      nr_r       <= in_err_yaw[15];
      eyaw_mag_r <= myaw;
    end
  end

  always_comb begin
    rx  = ({1'b0, px_r} + RND) >> FRAC_BITS;
    ry  = ({1'b0, py_r} + RND) >> FRAC_BITS;
    rr  = ({1'b0, pr_r} + RND) >> FRAC_BITS;
    rsq = {1'b0, exsq_r} + {1'b0, eysq_r};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x2_r     <= vcl_pkg::sat_mag(nx_r, rx);
      y2_r     <= cfg.holo ? vcl_pkg::sat_mag(ny_r, ry) : 16'sd0;
      r2_r     <= vcl_pkg::sat_mag(nr_r, rr);
      small2_r <= rsq < {3'd0, cfg.ip_trans_sq};
      tf2_r    <= cfg.turn_first && (eyaw_mag_r > {1'b0, cfg.head_thr});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x3_r     <= x2_r;
      y3_r     <= y2_r;
      r3_r     <= r2_r;
      xsq_r    <= x2_r * x2_r;
      ysq_r    <= y2_r * y2_r;
      small3_r <= small2_r;
      tf3_r    <= tf2_r;
    end
  end

  assign xsq_s = $signed(xsq_r);
  assign ysq_s = $signed(ysq_r);

  always_comb begin
    sq = $unsigned(xsq_s) + $unsigned(ysq_s);
    zero_lin = tf3_r || small3_r || (sq == 32'd0) || (cfg.max_lin == 16'd0);
    rm   = vcl_pkg::mag16(r3_r);
    rm_c = (rm > cfg.max_th) ? cfg.max_th : rm;
    if (tf3_r) begin
      lo = {1'b0, cfg.ip_min_rot};
    end else begin
      lo = cfg.min_th;
      if (small3_r && (cfg.min_th < {1'b0, cfg.ip_min_rot})) begin
        lo = {1'b0, cfg.ip_min_rot};
      end
    end
    if (rm_c < lo) begin
      rm_c = lo;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      job_r.x              <= x3_r;
      job_r.y              <= y3_r;
      job_r.yaw            <= vcl_pkg::sat_mag(r3_r[15], {17'd0, rm_c});
      job_r.sq             <= sq;
      job_r.ctl.zero_lin   <= zero_lin;
      job_r.ctl.need_over  <= sq > cfg.max_lin_sq;
      job_r.ctl.need_under <= (sq != 32'd0) && (sq < cfg.min_lin_sq);
    end
  end

endmodule

// ===== rtl/vcl_queue.sv =====
// ----------------------------------------------------------------------------
// vcl_queue
// Two-entry queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module vcl_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  vcl_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output vcl_pkg::job_t pop_job,
  output logic          empty
);

  vcl_pkg::job_t mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          do_push, do_pop;

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= !wp_r;
      if (do_pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== rtl/vcl_back.sv =====
// ----------------------------------------------------------------------------
// vcl_back
// Speed scaling when needed: bit-pair square root, then one or two rounded
// divisions of x and y times a limit by the speed; then an output register.
// ----------------------------------------------------------------------------
module vcl_back (
  input  logic               clk,
  input  logic               rst_n,
  input  vcl_pkg::cfg_t      cfg,
  input  logic               q_empty,
  input  vcl_pkg::job_t      q_job,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [15:0] out_cmd_x,
  output logic signed [15:0] out_cmd_y,
  output logic signed [15:0] out_cmd_yaw
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SQRT = 7'b0000010,
    ST_MUL  = 7'b0000100,
    ST_NUM  = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_SAT  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } st_t;

  st_t st_r;

  logic signed [15:0] x_r, y_r, yaw_r;
  logic               xneg_r, yneg_r, under_r, phase_r;
  logic [31:0]        v_r, root_r, bit_r;
  logic [5:0]         cnt_r;
  logic [31:0]        mx_r, my_r;
  logic [32:0]        nx_r, ny_r, qx_r, qy_r;
  logic [16:0]        remx_r, remy_r;
  logic               ovld_r;
  logic signed [15:0] ox_r, oy_r, oyaw_r;

  logic [31:0] trial;
  logic [15:0] lim;
  logic [16:0] dvs;
  logic [17:0] rnx, rny;

  assign q_pop       = (st_r == ST_IDLE) && !q_empty;
  assign out_empty   = !ovld_r;
  assign out_cmd_x   = ox_r;
  assign out_cmd_y   = oy_r;
  assign out_cmd_yaw = oyaw_r;

  always_comb begin
    trial = root_r + bit_r;
    lim   = phase_r ? cfg.min_lin : cfg.max_lin;
    dvs   = {root_r[15:0], 1'b0};
    rnx   = {remx_r, nx_r[32]};
    rny   = {remy_r, ny_r[32]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      case (st_r)
        ST_IDLE: begin
          if (!q_empty) begin
            if (q_job.ctl.zero_lin || !(q_job.ctl.need_over || q_job.ctl.need_under)) begin
              st_r <= ST_OUT;
            end else begin
              st_r <= ST_SQRT;
            end
          end
        end
        ST_SQRT: if (cnt_r == 6'd0) st_r <= ST_MUL;
        ST_MUL:  st_r <= ST_NUM;
        ST_NUM:  st_r <= ST_DIV;
        ST_DIV:  if (cnt_r == 6'd0) st_r <= ST_SAT;
        ST_SAT:  st_r <= (!phase_r && under_r) ? ST_MUL : ST_OUT;
        ST_OUT:  if (!ovld_r || out_pop) st_r <= ST_IDLE;
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        x_r     <= q_job.ctl.zero_lin ? 16'sd0 : q_job.x;
        y_r     <= q_job.ctl.zero_lin ? 16'sd0 : q_job.y;
        yaw_r   <= q_job.yaw;
        under_r <= q_job.ctl.need_under;
        phase_r <= !q_job.ctl.need_over;
        v_r     <= q_job.sq;
        root_r  <= '0;
        bit_r   <= 32'd1 << 30;
        cnt_r   <= 6'd15;
      end
      ST_SQRT: begin
        if (v_r >= trial) begin
          v_r    <= v_r - trial;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - 6'd1;
      end
      ST_MUL: begin
        mx_r   <= vcl_pkg::mag16(x_r) * lim;
        my_r   <= vcl_pkg::mag16(y_r) * lim;
        xneg_r <= x_r[15];
        yneg_r <= y_r[15];
      end
      ST_NUM: begin
        // (2m + s) / 2s rounds half away from zero
        nx_r   <= {mx_r, 1'b0} + {17'd0, root_r[15:0]};
        ny_r   <= {my_r, 1'b0} + {17'd0, root_r[15:0]};
        remx_r <= '0;
        remy_r <= '0;
        qx_r   <= '0;
        qy_r   <= '0;
        cnt_r  <= 6'd32;
      end
      ST_DIV: begin
        nx_r <= nx_r << 1;
        ny_r <= ny_r << 1;
        if (rnx >= {1'b0, dvs}) begin
          remx_r <= 17'(rnx - {1'b0, dvs});
          qx_r   <= {qx_r[31:0], 1'b1};
        end else begin
          remx_r <= rnx[16:0];
          qx_r   <= {qx_r[31:0], 1'b0};
        end
        if (rny >= {1'b0, dvs}) begin
          remy_r <= 17'(rny - {1'b0, dvs});
          qy_r   <= {qy_r[31:0], 1'b1};
        end else begin
          remy_r <= rny[16:0];
          qy_r   <= {qy_r[31:0], 1'b0};
        end
        cnt_r <= cnt_r - 6'd1;
      end
      ST_SAT: begin
        x_r     <= vcl_pkg::sat_mag(xneg_r, qx_r);
        y_r     <= vcl_pkg::sat_mag(yneg_r, qy_r);
        phase_r <= 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (st_r == ST_OUT) begin
      if (!ovld_r || out_pop) ovld_r <= 1'b1;
    end else if (out_pop) begin
      ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((st_r == ST_OUT) && (!ovld_r || out_pop)) begin
      ox_r   <= x_r;
      oy_r   <= cfg.holo ? y_r : 16'sd0;
      oyaw_r <= yaw_r;
    end
  end

endmodule

// ===== rtl/vcl_checker.sv =====
// ----------------------------------------------------------------------------
// vcl_checker
// Port-level checks on the velocity command limiter, bound to the top level.
// ----------------------------------------------------------------------------
`include "velocity_command_limiter_assert.svh"

module vcl_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_empty,
  input logic               out_pop,
  input logic signed [15:0] out_cmd_x,
  input logic signed [15:0] out_cmd_y,
  input logic signed [15:0] out_cmd_yaw,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [2:0]         cfg_addr,
  input logic [31:0]        cfg_data
);

  logic        holo_r;
  logic        stall;
  logic        y_ok;
  logic [47:0] out_cmd;

  // shadow of the holonomic mode bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holo_r <= vcl_pkg::RST_MODE[0];
    end else if (cfg_valid && cfg_ready && (cfg_addr == vcl_pkg::REG_MODE)) begin
      holo_r <= cfg_data[0];
    end
  end

  assign stall   = !out_empty && !out_pop;
  assign y_ok    = out_empty || holo_r || (out_cmd_y == 16'sd0);
  assign out_cmd = {out_cmd_x, out_cmd_y, out_cmd_yaw};

  `VCL_ASSERT_ALWAYS(a_cfg_ready, cfg_ready, "config channel not ready")
  `VCL_ASSERT_ALWAYS(a_nonholo_y, y_ok, "lateral command on non-holonomic base")
  `VCL_ASSERT_NEXT(a_out_hold, stall, !out_empty && $stable(out_cmd), "result moved while stalled")

endmodule

bind velocity_command_limiter vcl_checker u_vcl_checker (.*);

// ===== tb/velocity_command_limiter_tb.sv =====
// ----------------------------------------------------------------------------
// velocity_command_limiter_tb
// Drives velocity requests through the limiter under several register
// settings and checks every command against an in-bench predictor of the
// gains, speed limits, turn-first and in-place rotation rules.
// ----------------------------------------------------------------------------
module velocity_command_limiter_tb;

  localparam int FRAC = 12;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] yaw;
  } vec_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic signed [15:0] in_err_x = '0;
  logic signed [15:0] in_err_y = '0;
  logic signed [15:0] in_err_yaw = '0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic signed [15:0] out_cmd_x;
  logic signed [15:0] out_cmd_y;
  logic signed [15:0] out_cmd_yaw;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_addr = '0;
  logic [31:0]        cfg_data = '0;

  // shadow copy of the register file
  logic [15:0] trans_gain, rot_gain;
  logic [31:0] lin_limits, rot_limits;
  logic [14:0] ip_min_rot, ip_trans, head_thr;
  logic [1:0]  mode;

  vec_t   requests[$];
  vec_t   cmd_due[$];
  int     n_accepted = 0;
  int     n_results = 0;
  int     n_errors = 0;
  int     n_cfg = 0;
  int     cycles = 0;
  int     hold_left = 0;
  bit     held = 1'b0;
  logic   calm;

  velocity_command_limiter DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  assign calm = (n_accepted >= 400) && (n_accepted < 560);

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint apply_gain(longint a, longint g);
    longint m;
    m = (((a < 0) ? -a : a) * g + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    return sat16((a < 0) ? -m : m);
  endfunction

  function automatic longint rescale(longint a, longint lim, longint s);
    longint q;
    q = (2 * ((a < 0) ? -a : a) * lim + s) / (2 * s);
    return sat16((a < 0) ? -q : q);
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else
        r = r >>> 1;
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic vec_t limit_command(vec_t req);
    longint ex, ey, eyaw, x, y, r, rm, sq, s, max_lin, min_lin, max_th, min_th;
    longint ipm, ipt, hth;
    bit     holo, rneg;
    vec_t   c;
    ex = longint'(req.x); ey = longint'(req.y); eyaw = longint'(req.yaw);
    holo = mode[0];
    max_lin = longint'(lin_limits[31:16]); min_lin = longint'(lin_limits[15:0]);
    max_th = longint'(rot_limits[31:16]);  min_th = longint'(rot_limits[15:0]);
    ipm = longint'(ip_min_rot); ipt = longint'(ip_trans); hth = longint'(head_thr);
    x = apply_gain(ex, longint'(trans_gain));
    y = holo ? apply_gain(ey, longint'(trans_gain)) : 0;
    r = apply_gain(eyaw, longint'(rot_gain));
    rneg = r < 0;
    rm = rneg ? -r : r;
    if (mode[1] && ((eyaw < 0) ? -eyaw : eyaw) > hth) begin
      x = 0; y = 0;
      if (rm > max_th) rm = max_th;
      if (rm < ipm) rm = ipm;
    end else begin
      sq = x * x + y * y;
      if (sq == 0 || max_lin == 0) begin
        x = 0; y = 0;
      end else begin
        s = int_sqrt(sq);
        if (sq > max_lin * max_lin) begin
          x = rescale(x, max_lin, s);
          y = rescale(y, max_lin, s);
        end
        if (sq < min_lin * min_lin) begin
          x = rescale(x, min_lin, s);
          y = rescale(y, min_lin, s);
        end
      end
      if (rm > max_th) rm = max_th;
      if (rm < min_th) rm = min_th;
      // small raw translation: rotate in place
      if (ex * ex + ey * ey < ipt * ipt) begin
        if (rm < ipm) rm = ipm;
        x = 0; y = 0;
      end
    end
    if (!holo) y = 0;
    r = sat16(rneg ? -rm : rm);
    c.x = x[15:0];
    c.y = y[15:0];
    c.yaw = r[15:0];
    return c;
  endfunction

  // sender
  always @(negedge clk) begin
    bit idle;
    idle = !calm && ($urandom_range(0, 99) < 33);
    if (rst_n && requests.size() > 0 && !idle) begin
      in_push <= 1'b1;
      in_err_x <= requests[0].x;
      in_err_y <= requests[0].y;
      in_err_yaw <= requests[0].yaw;
    end else
      in_push <= 1'b0;
  end

  // receiver, with one long hold-off to back the block up
  always @(negedge clk) begin
    if (!held && n_results >= 300) begin
      held = 1'b1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_pop <= 1'b0;
    end else
      out_pop <= rst_n && (calm || $urandom_range(0, 99) >= 33);
  end

  // monitor
  always @(posedge clk) begin
    vec_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d commands outstanding", $time, cmd_due.size());
      $display("** velocity_command_limiter: FAILED **");
      $finish;
    end else begin
      if (rst_n && in_push && !in_full) begin
        cmd_due.insert(cmd_due.size(), limit_command(requests[0]));
        void'(requests.pop_front());
        n_accepted <= n_accepted + 1;
      end
      if (rst_n && out_pop && !out_empty) begin
        n_results <= n_results + 1;
        if (cmd_due.size() == 0) begin
          n_errors <= n_errors + 1;
          $display("%0t: unexpected command x=%0d y=%0d yaw=%0d", $time,
                   out_cmd_x, out_cmd_y, out_cmd_yaw);
        end else begin
          e = cmd_due.pop_front();
          if (e.x !== out_cmd_x || e.y !== out_cmd_y || e.yaw !== out_cmd_yaw) begin
            n_errors <= n_errors + 1;
            $display("%0t: mismatch expected x=%0d y=%0d yaw=%0d actual x=%0d y=%0d yaw=%0d",
                     $time, e.x, e.y, e.yaw, out_cmd_x, out_cmd_y, out_cmd_yaw);
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    n_cfg++;
    case (addr)
      vcl_pkg::REG_TRANS_GAIN: trans_gain = data[15:0];
      vcl_pkg::REG_ROT_GAIN:   rot_gain = data[15:0];
      vcl_pkg::REG_LIN_LIMITS: lin_limits = data;
      vcl_pkg::REG_ROT_LIMITS: rot_limits = data;
      vcl_pkg::REG_IP_MIN_ROT: ip_min_rot = data[14:0];
      vcl_pkg::REG_IP_TRANS:   ip_trans = data[14:0];
      vcl_pkg::REG_HEAD_THR:   head_thr = data[14:0];
      vcl_pkg::REG_MODE:       mode = data[1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [15:0] tg, input logic [15:0] rg,
                           input logic [31:0] ll, input logic [31:0] rl,
                           input logic [14:0] ipm, input logic [14:0] ipt,
                           input logic [14:0] ht, input logic [1:0] md);
    write_reg(vcl_pkg::REG_TRANS_GAIN, 32'(tg));
    write_reg(vcl_pkg::REG_ROT_GAIN, 32'(rg));
    write_reg(vcl_pkg::REG_LIN_LIMITS, ll);
    write_reg(vcl_pkg::REG_ROT_LIMITS, rl);
    write_reg(vcl_pkg::REG_IP_MIN_ROT, 32'(ipm));
    write_reg(vcl_pkg::REG_IP_TRANS, 32'(ipt));
    write_reg(vcl_pkg::REG_HEAD_THR, 32'(ht));
    write_reg(vcl_pkg::REG_MODE, 32'(md));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_req(input int x, input int y, input int yaw);
    vec_t v;
    v.x = 16'(x); v.y = 16'(y); v.yaw = 16'(yaw);
    requests.insert(requests.size(), v);
  endtask

  task automatic drain;
    while (requests.size() > 0 || cmd_due.size() > 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 255));
      default: return 16'($urandom_range(0, 16'h3FFF));
    endcase
  endfunction

  function automatic logic [14:0] pick15();
    case ($urandom_range(0, 5))
      0: return 15'h0000;
      1: return 15'h7FFF;
      default: return 15'($urandom_range(0, 15'h1FFF));
    endcase
  endfunction

  function automatic int pick_field();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 65535) - 32768;
      1: return $urandom_range(0, 64) - 32;
      2: return $urandom_range(0, 1) ? 32767 : -32768;
      default: return $urandom_range(0, 8192) - 4096;
    endcase
  endfunction

  initial begin
    trans_gain = vcl_pkg::RST_TRANS_GAIN;
    rot_gain = vcl_pkg::RST_ROT_GAIN;
    lin_limits = vcl_pkg::RST_LIN_LIMITS;
    rot_limits = vcl_pkg::RST_ROT_LIMITS;
    ip_min_rot = '0;
    ip_trans = '0;
    head_thr = '0;
    mode = vcl_pkg::RST_MODE;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: zero vector, extremes, over speed
    queue_req(0, 0, 0);
    queue_req(32767, 32767, 32767);
    queue_req(-32768, -32768, -32768);
    queue_req(100, -50, 0);
    queue_req(-32768, 0, 1);
    queue_req(0, 32767, -1);
    drain();

    // big gains, min above max, non-holonomic, zero yaw with min imposed
    write_all(16'hFFFF, 16'hFFFF, 32'h0100_0400, 32'h0800_0010, 15'd0, 15'd0, 15'd0, 2'd0);
    queue_req(0, 0, 0);
    queue_req(10, 5, 0);
    queue_req(32767, -32768, 32767);
    queue_req(-3, 7, -32768);
    queue_req(0, 4000, 0);
    drain();

    // turn first plus in-place rotation
    write_all(16'd4096, 16'd2048, 32'h1000_0200, 32'h2000_0100, 15'h7FFF, 15'd300,
              15'd1000, 2'd3);
    queue_req(5000, 5000, 1001);
    queue_req(5000, 5000, -1000);
    queue_req(100, 100, 0);
    queue_req(-200, 100, -1);
    queue_req(32767, 0, -32768);
    drain();

    // zero maximum, zero gains, extreme thresholds
    write_all(16'd0, 16'd0, 32'h0000_FFFF, 32'hFFFF_FFFF, 15'h7FFF, 15'h7FFF,
              15'h7FFF, 2'd2);
    queue_req(1, 1, 1);
    queue_req(-32768, 32767, -32768);
    queue_req(0, 0, 0);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_all(pick16(), pick16(), {pick16(), pick16()}, {pick16(), pick16()},
                pick15(), $urandom_range(0, 1) ? 15'($urandom_range(0, 600)) : pick15(),
                pick15(), 2'($urandom_range(0, 3)));
      for (int i = 0; i < 155; i++) queue_req(pick_field(), pick_field(), pick_field());
      drain();
    end

    $display("Covered %0d requests and %0d commands over %0d register writes.",
             n_accepted, n_results, n_cfg);
    if (n_errors == 0)
      $display("** velocity_command_limiter: PASSED **");
    else
      $display("** velocity_command_limiter: FAILED **");
    $finish;
  end

endmodule
